[sv/kcrft_pkg.sv]
// Shared types and constants of the k-mer count row filter table.
// No dependencies; imported by every module of the block but kcrft_ram.
package kcrft_pkg;

  localparam int DEF_MAX_SAMPLES = 16;
  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_KMER_BASES  = 32;

  localparam int PADDR_W = 4;
  localparam logic [4:0] RESET_ACTIVE_SAMPLES = 5'd16;

  typedef enum logic [2:0] {
    OP_SET_ANCHOR = 3'd0,
    OP_COUNT      = 3'd1,
    OP_READ_TOTAL = 3'd2,
    OP_READ_ENTRY = 3'd3,
    OP_READ_SUM   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    REG_MIN_ROW_TOTAL  = 2'd0,
    REG_MIN_ROW_PEAK   = 2'd1,
    REG_ACTIVE_SAMPLES = 2'd2
  } reg_addr_t;

  typedef enum logic [1:0] {
    RD_NONE  = 2'd0,
    RD_COUNT = 2'd1,
    RD_SUM   = 2'd2
  } rd_src_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [63:0] kmer;
    logic [31:0] count_value;
    logic [3:0]  sample_index;
    logic [9:0]  row_index;
  } in_item_t;

  typedef struct packed {
    logic        row_done;
    logic        accepted;
    logic        table_full;
    logic [31:0] row_sum;
    logic [31:0] row_peak;
    logic [10:0] stored_rows;
    logic [31:0] grand_total;
    logic [31:0] read_value;
    logic [63:0] read_kmer;
  } out_item_t;

  typedef struct packed {
    logic [31:0] min_row_total;
    logic [31:0] min_row_peak;
    logic [4:0]  active_samples;
  } cfg_regs_t;

  typedef struct packed {
    out_item_t  base;
    rd_src_t    rd_src;
    logic       kmer_from_ram;
    logic [3:0] sample_index;
  } meta_t;

endpackage

[sv/kcrft_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kcrft_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/kcrft_cfg.sv]
// Configuration registers behind the APB-style port.
// Depends on kcrft_pkg.
module kcrft_cfg import kcrft_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_regs_t          cfg
);

  reg_addr_t sel;

  assign sel    = reg_addr_t'(paddr[3:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_row_total  <= '0;
      cfg.min_row_peak   <= '0;
      cfg.active_samples <= RESET_ACTIVE_SAMPLES;
    end else if (psel && penable && pwrite) begin
      unique case (sel)
        REG_MIN_ROW_TOTAL:  cfg.min_row_total  <= pwdata;
        REG_MIN_ROW_PEAK:   cfg.min_row_peak   <= pwdata;
        REG_ACTIVE_SAMPLES: cfg.active_samples <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_MIN_ROW_TOTAL:  prdata = cfg.min_row_total;
      REG_MIN_ROW_PEAK:   prdata = cfg.min_row_peak;
      REG_ACTIVE_SAMPLES: prdata = {27'd0, cfg.active_samples};
      default:            prdata = '0;
    endcase
  end

endmodule

[sv/kcrft_state.sv]
// Anchor, pending row, totals and row acceptance; issues table writes and reads.
// Depends on kcrft_pkg.
module kcrft_state import kcrft_pkg::*; #(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int KMER_BASES  = DEF_KMER_BASES
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         fire,
  input  in_item_t                                     item,
  input  cfg_regs_t                                    cfg,
  output logic                                         wr_en,
  output logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] wr_addr,
  output logic [32*MAX_SAMPLES-1:0]                    wr_counts,
  output logic [31:0]                                  wr_sum,
  output logic [2*KMER_BASES-1:0]                      wr_kmer,
  output logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] rd_addr,
  output meta_t                                        meta
);

  localparam int SIDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int POS_W  = $clog2(MAX_SAMPLES + 1);
  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int KMER_W = 2 * KMER_BASES;

  logic [KMER_W-1:0] anchor;
  logic [CNT_W-1:0]  row_count;
  logic [31:0]       total_sum;
  logic [31:0]       sample_total [MAX_SAMPLES];
  logic [31:0]       pend_count [MAX_SAMPLES];
  logic [31:0]       pend_sum;
  logic [31:0]       pend_peak;
  logic [POS_W-1:0]  pend_pos;

  op_t               op;
  logic [KMER_W-1:0] kmer_in;
  logic [POS_W-1:0]  n;
  logic [31:0]       sum_new;
  logic [31:0]       peak_new;
  logic [POS_W-1:0]  pos_new;
  logic              done;
  logic              pass;
  logic              tab_full;
  logic              accept;
  logic [31:0]       row_val [MAX_SAMPLES];
  logic              ridx_ok;
  logic              sidx_ok;
  logic [CNT_W-1:0]  row_count_next;
  logic [31:0]       total_sum_next;
  logic [KMER_W-1:0] anchor_next;

  always_comb begin
    op      = op_t'(item.operation);
    kmer_in = item.kmer[KMER_W-1:0];

    priority if (cfg.active_samples == 5'd0) begin
      n = POS_W'(1);
    end else if (32'(cfg.active_samples) > MAX_SAMPLES) begin
      n = POS_W'(MAX_SAMPLES);
    end else begin
      n = POS_W'(cfg.active_samples);
    end

    sum_new  = pend_sum + item.count_value;
    peak_new = (item.count_value > pend_peak) ? item.count_value : pend_peak;
    pos_new  = pend_pos + POS_W'(1);
    done     = (op == OP_COUNT) && (pos_new >= n);
    pass     = (sum_new != 32'd0) && (sum_new >= cfg.min_row_total)
               && (peak_new >= cfg.min_row_peak);
    tab_full = 32'(row_count) >= TABLE_DEPTH;
    accept   = done && pass && !tab_full;

    for (int j = 0; j < MAX_SAMPLES; j++) begin
      if (POS_W'(j) >= n) begin
        row_val[j] = '0;
      end else if (POS_W'(j) == pend_pos) begin
        row_val[j] = item.count_value;
      end else begin
        row_val[j] = pend_count[j];
      end
      wr_counts[32*j +: 32] = row_val[j];
    end

    priority if (op == OP_SET_ANCHOR) begin
      row_count_next = '0;
      total_sum_next = '0;
      anchor_next    = kmer_in;
    end else if (accept) begin
      row_count_next = row_count + CNT_W'(1);
      total_sum_next = total_sum + sum_new;
      anchor_next    = anchor;
    end else begin
      row_count_next = row_count;
      total_sum_next = total_sum;
      anchor_next    = anchor;
    end

    ridx_ok = 32'(item.row_index) < 32'(row_count);
    sidx_ok = 32'(item.sample_index) < 32'(n);

    meta.base.row_done    = done;
    meta.base.accepted    = accept;
    meta.base.table_full  = done && pass && tab_full;
    meta.base.row_sum     = done ? sum_new : 32'd0;
    meta.base.row_peak    = done ? peak_new : 32'd0;
    meta.base.stored_rows = 11'(row_count_next);
    meta.base.grand_total = total_sum_next;
    meta.base.read_value  = (op == OP_READ_TOTAL && sidx_ok)
                            ? sample_total[SIDX_W'(item.sample_index)] : 32'd0;
    meta.base.read_kmer   = 64'(anchor_next);
    meta.sample_index     = item.sample_index;
    meta.kmer_from_ram    = (op == OP_READ_ENTRY || op == OP_READ_SUM) && ridx_ok;

    priority if (op == OP_READ_ENTRY && ridx_ok && sidx_ok) begin
      meta.rd_src = RD_COUNT;
    end else if (op == OP_READ_SUM && ridx_ok) begin
      meta.rd_src = RD_SUM;
    end else begin
      meta.rd_src = RD_NONE;
    end
  end

  assign wr_en   = fire && accept;
  assign wr_addr = ADDR_W'(row_count);
  assign wr_sum  = sum_new;
  assign wr_kmer = kmer_in;
  assign rd_addr = ADDR_W'(item.row_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      anchor    <= '0;
      row_count <= '0;
      total_sum <= '0;
      pend_sum  <= '0;
      pend_peak <= '0;
      pend_pos  <= '0;
      for (int j = 0; j < MAX_SAMPLES; j++) begin
        sample_total[j] <= '0;
      end
    end else if (fire) begin
      anchor    <= anchor_next;
      row_count <= row_count_next;
      total_sum <= total_sum_next;
      if (op == OP_SET_ANCHOR) begin
        pend_sum  <= '0;
        pend_peak <= '0;
        pend_pos  <= '0;
        for (int j = 0; j < MAX_SAMPLES; j++) begin
          sample_total[j] <= '0;
        end
      end else if (op == OP_COUNT) begin
        if (done) begin
          pend_sum  <= '0;
          pend_peak <= '0;
          pend_pos  <= '0;
          if (accept) begin
            for (int j = 0; j < MAX_SAMPLES; j++) begin
              sample_total[j] <= sample_total[j] + row_val[j];
            end
          end
        end else begin
          pend_sum  <= sum_new;
          pend_peak <= peak_new;
          pend_pos  <= pos_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && op == OP_COUNT && 32'(pend_pos) < MAX_SAMPLES) begin
      pend_count[pend_pos[SIDX_W-1:0]] <= item.count_value;
    end
  end

`ifndef SYNTHESIS
  a_row_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(row_count) <= TABLE_DEPTH)
    else $error("row count beyond table depth");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    32'(pend_pos) < MAX_SAMPLES)
    else $error("pending position beyond sample count");

  a_anchor_clears: assert property (@(posedge clk) disable iff (rst)
    fire && op == OP_SET_ANCHOR |=> row_count == '0 && total_sum == 32'd0
    && pend_pos == '0)
    else $error("new anchor did not clear the table");

  a_accept_grows: assert property (@(posedge clk) disable iff (rst)
    fire && accept |=> row_count == $past(row_count) + CNT_W'(1))
    else $error("accepted row not counted");
`endif

endmodule

[sv/kcrft_out.sv]
// Read-data stage and result register: merges table read data into the result.
// Depends on kcrft_pkg.
module kcrft_out import kcrft_pkg::*; #(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
  parameter int KMER_BASES  = DEF_KMER_BASES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          fire,
  input  meta_t                         meta,
  input  logic [32*MAX_SAMPLES-1:0]     ram_counts,
  input  logic [31:0]                   ram_sum,
  input  logic [2*KMER_BASES-1:0]       ram_kmer,
  output logic                          result_valid,
  output out_item_t                     result
);

  localparam int SIDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

  logic        s2_valid;
  meta_t       s2_meta;
  logic [31:0] cnt_word [MAX_SAMPLES];
  out_item_t   merged;

  always_comb begin
    for (int j = 0; j < MAX_SAMPLES; j++) begin
      cnt_word[j] = ram_counts[32*j +: 32];
    end
    merged = s2_meta.base;
    if (s2_meta.kmer_from_ram) begin
      merged.read_kmer = 64'(ram_kmer);
    end
    unique case (s2_meta.rd_src)
      RD_COUNT: merged.read_value = cnt_word[SIDX_W'(s2_meta.sample_index)];
      RD_SUM:   merged.read_value = ram_sum;
      RD_NONE:  ;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      s2_valid     <= fire;
      result_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_meta <= meta;
      result  <= merged;
    end
  end

endmodule

[sv/kmer_count_row_filter_table_unit.sv]
// Top level of the k-mer count row filter table.
// Depends on kcrft_pkg, kcrft_cfg, kcrft_state, kcrft_out and kcrft_ram.
//
// One result per item; the block takes an item every cycle while results
// are taken, and a result passes through the input register, then the table
// read, then the result register. Each item updates the anchor, pending row and
// totals when it leaves the input register; an accepted row is written to the
// count, row-sum and k-mer tables in the same cycle, one whole row per write, and
// reads go through the registered read port of those tables. item_ready
// drops only while a result is held and the input register is occupied.
// The tables need no clearing after reset: only stored rows are ever read.
module kmer_count_row_filter_table_unit import kcrft_pkg::*; #(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int KMER_BASES  = DEF_KMER_BASES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  in_item_t           item,
  output logic               result_valid,
  input  logic               result_ready,
  output out_item_t          result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int ROW_W  = 32 * MAX_SAMPLES;
  localparam int KMER_W = 2 * KMER_BASES;

  cfg_regs_t           cfg;
  logic                s1_valid;
  in_item_t            s1_item;
  logic                en;
  logic                fire;
  meta_t               meta;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ROW_W-1:0]    wr_counts;
  logic [31:0]         wr_sum;
  logic [KMER_W-1:0]   wr_kmer;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ROW_W-1:0]    ram_counts;
  logic [31:0]         ram_sum;
  logic [KMER_W-1:0]   ram_kmer;

  assign en         = !result_valid || result_ready;
  assign fire       = s1_valid && en;
  assign item_ready = !s1_valid || en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1_item <= item;
    end
  end

  kcrft_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kcrft_state #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .TABLE_DEPTH (TABLE_DEPTH),
    .KMER_BASES  (KMER_BASES)
  ) u_state (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (s1_item),
    .cfg       (cfg),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_counts (wr_counts),
    .wr_sum    (wr_sum),
    .wr_kmer   (wr_kmer),
    .rd_addr   (rd_addr),
    .meta      (meta)
  );

  kcrft_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_DEPTH)) u_count_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_counts),
    .re    (fire),
    .raddr (rd_addr),
    .rdata (ram_counts)
  );

  kcrft_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_sum_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_sum),
    .re    (fire),
    .raddr (rd_addr),
    .rdata (ram_sum)
  );

  kcrft_ram #(.WIDTH(KMER_W), .DEPTH(TABLE_DEPTH)) u_kmer_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_kmer),
    .re    (fire),
    .raddr (rd_addr),
    .rdata (ram_kmer)
  );

  kcrft_out #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .KMER_BASES  (KMER_BASES)
  ) u_out (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .fire         (fire),
    .meta         (meta),
    .ram_counts   (ram_counts),
    .ram_sum      (ram_sum),
    .ram_kmer     (ram_kmer),
    .result_valid (result_valid),
    .result       (result)
  );

`ifndef SYNTHESIS
  a_accept_implies_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.accepted |-> result.row_done && !result.table_full)
    else $error("accepted row without completion");

  a_idle_row_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.row_done |-> result.row_sum == 32'd0
    && result.row_peak == 32'd0 && !result.accepted)
    else $error("row fields set without a completed row");
`endif

endmodule
